// ===== hw/rtl/dblgs_pkg.sv =====
// Shared types and constants for the depth and branch limited graph search.
package dblgs_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_ORDER    = 3'd2;
  localparam logic [2:0] KIND_PATH     = 3'd3;
  localparam logic [2:0] KIND_NOTFOUND = 3'd4;

  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_GOAL   = 2'd1;
  localparam logic [1:0] CFG_BRANCH = 2'd2;
  localparam logic [1:0] CFG_DEPTH  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic add_edge;   // perform edge write
    logic clear;      // clear successor counts
    logic init;       // begin search: clear marks, try root
    logic step;       // one walk step (pop, issue store read or act on it)
    logic emit_rst;   // reset emit pointer
    logic emit_adv;   // advance emit pointer
  } dblgs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;       // edge would be dropped
    logic found;
    logic failed;
    logic emit_in_order; // emit pointer within visit order
    logic emit_end;      // current emit entry is the final one
  } dblgs_sts_t;

endpackage

// ===== hw/rtl/dblgs_datapath.sv =====
// Datapath: graph store, search stack, visit order and emit pointer.
module dblgs_datapath import dblgs_pkg::*; #(
  parameter int NODE_COUNT = 32,
  parameter int MAX_DEGREE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dblgs_cmd_t cmd,
  output dblgs_sts_t sts,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_from_node,
  input  logic [4:0] in_to_node,
  input  logic [4:0] start_node,
  input  logic [4:0] goal_node,
  input  logic [5:0] branch_limit,
  input  logic [4:0] depth_limit,
  output logic [4:0] emit_node,
  output logic [1:0] op_q
);

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int AW = (NODE_COUNT * MAX_DEGREE > 1) ? $clog2(NODE_COUNT * MAX_DEGREE) : 1;

  logic [4:0] from_r, to_r;
  logic [1:0] op_r;
  logic [5:0] cnt_r [NODE_COUNT];
  logic [NODE_COUNT-1:0] mark_r;
  logic [4:0] mem [NODE_COUNT*MAX_DEGREE];
  logic [4:0] rd_r;
  logic       rd_vld_r;

  logic [4:0] ord_r [NODE_COUNT];
  logic [5:0] vcnt_r;
  logic [4:0] snode_r [NODE_COUNT];
  logic [5:0] snext_r [NODE_COUNT];
  logic [5:0] srank_r [NODE_COUNT];
  logic [5:0] ssize_r;
  logic       found_r, failed_r;
  logic [6:0] eptr_r;

  assign op_q = op_r;

  wire from_ok = {1'b0, from_r} < 6'(NODE_COUNT);
  wire to_ok   = {1'b0, to_r} < 6'(NODE_COUNT);
  wire [5:0] fcnt = from_ok ? cnt_r[from_r[NW-1:0]] : '0;
  wire drop = !from_ok || !to_ok || (fcnt >= 6'(MAX_DEGREE));

  wire [5:0] top = ssize_r - 6'd1;
  wire [NW-1:0] ti = top[NW-1:0];
  wire [4:0] tv = snode_r[ti];
  wire [5:0] tnext = snext_r[ti];
  wire [5:0] trank = srank_r[ti];
  wire exhausted = tnext >= cnt_r[tv[NW-1:0]];
  wire [4:0] c = rd_r;
  wire c_ok = {1'b0, c} < 6'(NODE_COUNT);
  wire c_marked = c_ok ? mark_r[c[NW-1:0]] : 1'b1;
  wire lim_ok = (ssize_r <= {1'b0, depth_limit}) && (trank <= branch_limit) &&
                (ssize_r < 6'(NODE_COUNT)) && (vcnt_r < 6'(NODE_COUNT));
  wire start_ok = ({1'b0, start_node} < 6'(NODE_COUNT)) &&
                  ({1'b0, goal_node} < 6'(NODE_COUNT));

  logic [DW-1:0] rd_col;
  assign rd_col = tnext[DW-1:0];

  wire [AW-1:0] wr_addr = AW'(from_r[NW-1:0]) * AW'(MAX_DEGREE) + AW'(fcnt[DW-1:0]);
  wire [AW-1:0] rd_addr = AW'(tv[NW-1:0]) * AW'(MAX_DEGREE) + AW'(rd_col);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      from_r <= in_from_node;
      to_r   <= in_to_node;
      op_r   <= in_opcode;
    end
    if (cmd.add_edge && !drop)
      mem[wr_addr] <= to_r;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) cnt_r[i] <= '0;
      mark_r <= '0; vcnt_r <= '0; ssize_r <= '0;
      found_r <= 1'b0; failed_r <= 1'b0; rd_vld_r <= 1'b0; eptr_r <= '0;
    end else begin
      if (cmd.clear)
        for (int i = 0; i < NODE_COUNT; i++) cnt_r[i] <= '0;
      if (cmd.add_edge && !drop) cnt_r[from_r[NW-1:0]] <= fcnt + 6'd1;
      if (cmd.init) begin
        rd_vld_r <= 1'b0;
        found_r <= start_ok && (start_node == goal_node);
        failed_r <= !start_ok;
        if (!start_ok) begin
          mark_r <= '0; vcnt_r <= '0; ssize_r <= '0;
        end else begin
          mark_r <= NODE_COUNT'(1) << start_node[NW-1:0];
          ord_r[0] <= start_node; vcnt_r <= 6'd1;
          snode_r[0] <= start_node; snext_r[0] <= '0; srank_r[0] <= 6'd1;
          ssize_r <= 6'd1;
        end
      end else if (cmd.step) begin
        if (ssize_r == '0) failed_r <= 1'b1;
        else if (!rd_vld_r) begin
          // phase one: pop or issue store read
          if (exhausted) begin
            ssize_r <= top;
            if (top != '0) srank_r[ti - NW'(1)] <= srank_r[ti - NW'(1)] + 6'd1;
          end else begin
            rd_vld_r <= 1'b1;
          end
        end else begin
          rd_vld_r <= 1'b0;
          snext_r[ti] <= tnext + 6'd1;
          if (!c_marked) begin
            if (lim_ok) begin
              mark_r[c[NW-1:0]] <= 1'b1;
              ord_r[vcnt_r[NW-1:0]] <= c; vcnt_r <= vcnt_r + 6'd1;
              snode_r[ssize_r[NW-1:0]] <= c;
              snext_r[ssize_r[NW-1:0]] <= '0;
              srank_r[ssize_r[NW-1:0]] <= 6'd1;
              ssize_r <= ssize_r + 6'd1;
              if (c == goal_node) found_r <= 1'b1;
            end else begin
              srank_r[ti] <= trank + 6'd1;
            end
          end
        end
      end
      if (cmd.emit_rst) eptr_r <= '0;
      else if (cmd.emit_adv) eptr_r <= eptr_r + 7'd1;
    end
  end

  wire [6:0] ptr_p = eptr_r - {1'b0, vcnt_r};
  assign sts.emit_in_order = eptr_r < {1'b0, vcnt_r};
  assign sts.emit_end = (eptr_r + 7'd1) == ({1'b0, vcnt_r} + {1'b0, ssize_r});
  assign emit_node = sts.emit_in_order ? ord_r[eptr_r[NW-1:0]] : snode_r[ptr_p[NW-1:0]];
  assign sts.drop = drop;
  assign sts.found = found_r;
  assign sts.failed = failed_r;

endmodule

// ===== hw/rtl/dblgs_ctrl.sv =====
// Controller state machine sequencing edge loads, graph clears, searches and result emission.
module dblgs_ctrl import dblgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic       out_last,
  output logic       emit_sel,
  input  logic [1:0] op_q,
  input  dblgs_sts_t sts,
  output dblgs_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_EMIT = 5'b01000,
    S_ONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  assign in_stall = state_r != S_IDLE;
  assign out_valid = (state_r == S_EMIT) || (state_r == S_ONE);
  assign out_kind = (state_r == S_EMIT) ? (sts.emit_in_order ? KIND_ORDER : KIND_PATH)
                                        : kind_r;
  assign out_last = (state_r == S_ONE) || (!sts.emit_in_order && sts.emit_end);
  assign emit_sel = state_r == S_EMIT;

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        kind_nxt = KIND_DONE;
        state_nxt = S_ONE;
        case (op_q)
          OP_ADD: begin
            cmd.add_edge = 1'b1;
            if (sts.drop) kind_nxt = KIND_DROPPED;
          end
          OP_CLEAR: cmd.clear = 1'b1;
          OP_SEARCH: begin
            cmd.init = 1'b1;
            state_nxt = S_WALK;
          end
          default: ;
        endcase
      end
      S_WALK: begin
        cmd.emit_rst = 1'b1;
        if (sts.found) state_nxt = S_EMIT;
        else if (sts.failed) begin
          kind_nxt = KIND_NOTFOUND;
          state_nxt = S_ONE;
        end else cmd.step = 1'b1;
      end
      S_EMIT: if (!out_stall) begin
        cmd.emit_adv = 1'b1;
        if (out_last) state_nxt = S_IDLE;
      end
      S_ONE: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= KIND_DONE;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_walk_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !out_valid) else $error("output during walk");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> (state_r == S_IDLE))
    else $error("no return to idle after last");

endmodule

// ===== hw/rtl/depth_branch_limited_graph_search.sv =====
// Top level of the depth and branch limited graph search block.
// Edge loads, graph clears and unused opcodes take one transaction in and one result out.
// A search walks the stored graph with a step per successor examined (store read, then
// decision, split by the single successor store read port) and a pop per backtrack; the
// visit order and path then stream out one entry per cycle while out_stall is low. Input
// is stalled from acceptance until the last result of the transaction is taken.
module depth_branch_limited_graph_search import dblgs_pkg::*; #(
  parameter int NODE_COUNT = 32,
  parameter int MAX_DEGREE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_from_node,
  input  logic [4:0] in_to_node,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [4:0] out_result_node,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  logic [4:0] start_r, goal_r, depth_r;
  logic [5:0] branch_r;
  dblgs_cmd_t cmd;
  dblgs_sts_t sts;
  logic [4:0] emit_node;
  logic [1:0] op_q;
  logic emit_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; goal_r <= '0; branch_r <= 6'd32; depth_r <= 5'd31;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START:  start_r <= cfg_data[4:0];
        CFG_GOAL:   goal_r <= cfg_data[4:0];
        CFG_BRANCH: branch_r <= cfg_data;
        CFG_DEPTH:  depth_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  dblgs_datapath #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_from_node, .in_to_node,
    .start_node(start_r), .goal_node(goal_r), .branch_limit(branch_r),
    .depth_limit(depth_r), .emit_node, .op_q
  );

  dblgs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_kind,
    .out_last, .emit_sel, .op_q, .sts, .cmd
  );

  assign out_result_node = emit_sel ? emit_node : 5'd0;

endmodule
